// ----- src/opi_pkg.sv -----
`default_nettype none
package opi_pkg;

   // default parameter values
   localparam int FRAC_BITS_DEF = 16;
   localparam int TRIG_ITER_DEF = 16;

   // arctangent table depth and sequencer counter width
   localparam int ATAN_ENTRIES = 24;
   localparam int STEP_W = 5;

   // partial products of the angle multiply
   localparam int PARTS = 4;

   // request op codes
   localparam logic [1:0] OP_VELOCITY = 2'd0;
   localparam logic [1:0] OP_CLEAR    = 2'd1;
   localparam logic [1:0] OP_SET      = 2'd2;

   // 2^64 / (2*pi), radians to binary angle
   localparam logic [63:0] RAD_TO_BAM = 64'd2935890503282001226;

   // cordic gain 0.607253 in q4.30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic signed [33:0] ONE_Q30     = 34'sd1073741824;

   // datapath commands
   typedef enum logic [4:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_PROD,
      CMD_PSAVE,
      CMD_PART,
      CMD_ANGLE,
      CMD_ROT,
      CMD_TRIG,
      CMD_MUL_VC,
      CMD_ROUND_VC,
      CMD_MUL_VCT,
      CMD_MUL_VS,
      CMD_ROUND_VS,
      CMD_MUL_VST,
      CMD_ROUND_DY,
      CMD_COMMIT_VEL,
      CMD_COMMIT_POSE
   } opi_cmd_type;

   typedef struct packed {
      opi_cmd_type         cmd;
      logic [STEP_W-1:0]   step;
   } opi_ctrl_type;

   // sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_PROD,
      S_PSAVE,
      S_PART,
      S_ANGLE,
      S_ROT,
      S_TRIG,
      S_MUL_VC,
      S_ROUND_VC,
      S_MUL_VCT,
      S_MUL_VS,
      S_ROUND_VS,
      S_MUL_VST,
      S_ROUND_DY,
      S_COMMIT,
      S_POSE
   } opi_state_type;

   // arctangent of 2^-i as binary angle
   function automatic logic [31:0] atan_bam(input logic [STEP_W-1:0] idx);
      logic [31:0] r;
      case (idx)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- src/odometry_pose_integrator_core.sv -----
// Dead-reckoning pose integrator.
// Request channel (req_*): op, stamp, speed, yaw rate and a pose for the set op.
// Op velocity integrates one sample, op clear zeroes the pose, op set loads
// req_new_x/y/heading; any other op reports the pose unchanged.
// Result channel (rsp_*): one result per request with the pose after it,
// the echoed speed and yaw rate (zero for pose ops) and the mode used.
// Config channel (csr_*): integration mode, 0 Euler, 1 midpoint; always ready,
// write it only while no request is in flight.
// A velocity request runs the cordic loop, one rotation step per cycle, and
// nine products through the single shared 33x33 multiplier before its result
// is registered; a pose op goes straight from idle to its commit step.
// One request is worked on at a time; the next one is taken the cycle after
// a result is registered, even while that result is still waiting.
// A stalled receiver holds the result; a finished request then waits
// at its commit step until the result register frees.
// Synchronous reset clears pose, stamp history and mode, drops any result.
`default_nettype none
module odometry_pose_integrator_core #(
   parameter int FRAC_BITS       = opi_pkg::FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = opi_pkg::TRIG_ITER_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_op,
   input  wire logic [47:0]         req_stamp,
   input  wire logic signed [31:0]  req_linear_speed,
   input  wire logic signed [31:0]  req_yaw_rate,
   input  wire logic signed [47:0]  req_new_x,
   input  wire logic signed [47:0]  req_new_y,
   input  wire logic [31:0]         req_new_heading,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic signed [47:0]       rsp_pose_x,
   output logic signed [47:0]       rsp_pose_y,
   output logic [31:0]              rsp_pose_heading,
   output logic signed [31:0]       rsp_echo_speed,
   output logic signed [31:0]       rsp_echo_yaw_rate,
   output logic                     rsp_mode_used,
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic                csr_integration_mode
);
   import opi_pkg::*;

   opi_ctrl_type ctl;

   // config register takes a write at any time
   assign csr_ready = 1'b1;

   opi_ctrl #(
      .TRIG_ITERATIONS(TRIG_ITERATIONS)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_op(req_op),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .ctl(ctl)
   );

   opi_datapath #(
      .FRAC_BITS(FRAC_BITS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .ctl(ctl),
      .csr_write(csr_valid && csr_ready),
      .csr_integration_mode(csr_integration_mode),
      .req_op(req_op),
      .req_stamp(req_stamp),
      .req_linear_speed(req_linear_speed),
      .req_yaw_rate(req_yaw_rate),
      .req_new_x(req_new_x),
      .req_new_y(req_new_y),
      .req_new_heading(req_new_heading),
      .rsp_pose_x(rsp_pose_x),
      .rsp_pose_y(rsp_pose_y),
      .rsp_pose_heading(rsp_pose_heading),
      .rsp_echo_speed(rsp_echo_speed),
      .rsp_echo_yaw_rate(rsp_echo_yaw_rate),
      .rsp_mode_used(rsp_mode_used)
   );

endmodule
`default_nettype wire

// ----- src/opi_datapath.sv -----
`default_nettype none
module opi_datapath #(
   parameter int FRAC_BITS = opi_pkg::FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire opi_pkg::opi_ctrl_type ctl,
   input  wire logic                csr_write,
   input  wire logic                csr_integration_mode,
   input  wire logic [1:0]          req_op,
   input  wire logic [47:0]         req_stamp,
   input  wire logic signed [31:0]  req_linear_speed,
   input  wire logic signed [31:0]  req_yaw_rate,
   input  wire logic signed [47:0]  req_new_x,
   input  wire logic signed [47:0]  req_new_y,
   input  wire logic [31:0]         req_new_heading,
   output logic signed [47:0]       rsp_pose_x,
   output logic signed [47:0]       rsp_pose_y,
   output logic [31:0]              rsp_pose_heading,
   output logic signed [31:0]       rsp_echo_speed,
   output logic signed [31:0]       rsp_echo_yaw_rate,
   output logic                     rsp_mode_used
);
   import opi_pkg::*;

   localparam int DX_W  = 66 - FRAC_BITS;
   localparam int SUM_W = ((DX_W > 48) ? DX_W : 48) + 1;
   localparam int STEP_LO = 2 * FRAC_BITS + 32;
   localparam int HALF_LO = 2 * FRAC_BITS + 33;

   // configuration and accumulated state
   logic mode_ff;
   logic signed [47:0] x_ff, x_in, y_ff, y_in;
   logic [31:0] heading_ff, heading_in;
   logic [47:0] last_stamp_ff;
   logic seen_ff;

   // captured request
   logic [1:0] op_ff;
   logic signed [31:0] speed_ff, yaw_ff;
   logic signed [47:0] new_x_ff, new_y_ff;
   logic [31:0] new_heading_ff;
   logic [31:0] ts_ff;

   // working registers
   logic signed [65:0] mul_ff;
   logic [63:0] prod_ff;
   logic [127:0] acc_ff;
   logic signed [33:0] cx_ff, cy_ff, z_ff;
   logic flip_ff;
   logic signed [31:0] cos_ff, sin_ff;
   logic signed [32:0] vc_ff;
   logic signed [DX_W-1:0] dx_ff, dy_ff;
   logic signed [31:0] echo_v_ff, echo_w_ff;
   logic mode_used_ff;

   // sample interval with saturation, zero for the first sample or a stale stamp
   logic [47:0] stamp_diff;
   logic [31:0] ts_new;
   always_comb begin
      stamp_diff = req_stamp - last_stamp_ff;
      if (!seen_ff || req_stamp <= last_stamp_ff) begin
         ts_new = 32'd0;
      end else if (|stamp_diff[47:32]) begin
         ts_new = 32'hFFFFFFFF;
      end else begin
         ts_new = stamp_diff[31:0];
      end
   end

   // shared multiplier operand select
   logic signed [32:0] mul_a, mul_b;
   always_comb begin
      mul_a = 33'sd0;
      mul_b = 33'sd0;
      case (ctl.cmd)
         CMD_PROD: begin
            mul_a = 33'(yaw_ff);
            mul_b = $signed({1'b0, ts_ff});
         end
         CMD_PART: begin
            if (ctl.step < STEP_W'(2)) begin
               mul_a = $signed({1'b0, prod_ff[31:0]});
            end else begin
               mul_a = $signed({prod_ff[63], prod_ff[63:32]});
            end
            if (ctl.step[0]) begin
               mul_b = $signed({1'b0, RAD_TO_BAM[63:32]});
            end else begin
               mul_b = $signed({1'b0, RAD_TO_BAM[31:0]});
            end
         end
         CMD_MUL_VC: begin
            mul_a = 33'(speed_ff);
            mul_b = 33'(cos_ff);
         end
         CMD_MUL_VS: begin
            mul_a = 33'(speed_ff);
            mul_b = 33'(sin_ff);
         end
         CMD_MUL_VCT, CMD_MUL_VST: begin
            mul_a = vc_ff;
            mul_b = $signed({1'b0, ts_ff});
         end
         default: begin
            mul_a = 33'sd0;
            mul_b = 33'sd0;
         end
      endcase
   end

   // previous partial product placed at its weight
   logic [127:0] part_ext, part_term;
   always_comb begin
      part_ext = {{62{mul_ff[65]}}, mul_ff};
      case (ctl.step)
         STEP_W'(1): part_term = part_ext;
         STEP_W'(4): part_term = part_ext << 64;
         default:    part_term = part_ext << 32;
      endcase
   end

   // angle for the trig unit, folded into the right half plane
   logic [31:0] h_angle, h_fold;
   logic h_flip;
   always_comb begin
      h_angle = heading_ff + (mode_ff ? acc_ff[HALF_LO +: 32] : 32'd0);
      h_flip  = (h_angle[31:30] == 2'd1) || (h_angle[31:30] == 2'd2);
      h_fold  = h_flip ? (h_angle - 32'h80000000) : h_angle;
   end

   // cordic rotation step
   logic signed [33:0] cx_sh, cy_sh, atan_ext;
   always_comb begin
      cx_sh    = cx_ff >>> ctl.step;
      cy_sh    = cy_ff >>> ctl.step;
      atan_ext = $signed({2'b00, atan_bam(ctl.step)});
   end

   // clamp to unit range; the fold is undone when cos and sin are registered
   logic signed [31:0] cx_cl, cy_cl;
   always_comb begin
      if (cx_ff > ONE_Q30) cx_cl = 32'(ONE_Q30);
      else if (cx_ff < -ONE_Q30) cx_cl = 32'(-ONE_Q30);
      else cx_cl = 32'(cx_ff);
      if (cy_ff > ONE_Q30) cy_cl = 32'(ONE_Q30);
      else if (cy_ff < -ONE_Q30) cy_cl = 32'(-ONE_Q30);
      else cy_cl = 32'(cy_ff);
   end

   // round to nearest, ties up
   logic signed [65:0] rnd30_sum, rndf_sum;
   always_comb begin
      rnd30_sum = mul_ff + 66'sd536870912;
      rndf_sum  = mul_ff + (66'sd1 <<< (FRAC_BITS - 1));
   end

   // position update with saturation
   logic signed [SUM_W-1:0] x_sum, y_sum;
   logic signed [47:0] x_sat, y_sat;
   always_comb begin
      x_sum = SUM_W'(x_ff) + SUM_W'(dx_ff);
      y_sum = SUM_W'(y_ff) + SUM_W'(dy_ff);
      if ((&x_sum[SUM_W-1:47]) || !(|x_sum[SUM_W-1:47])) x_sat = x_sum[47:0];
      else x_sat = x_sum[SUM_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      if ((&y_sum[SUM_W-1:47]) || !(|y_sum[SUM_W-1:47])) y_sat = y_sum[47:0];
      else y_sat = y_sum[SUM_W-1] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
   end

   // next pose
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      heading_in = heading_ff;
      if (ctl.cmd == CMD_COMMIT_VEL) begin
         x_in = x_sat;
         y_in = y_sat;
         heading_in = heading_ff + acc_ff[STEP_LO +: 32];
      end else if (ctl.cmd == CMD_COMMIT_POSE) begin
         case (op_ff)
            OP_CLEAR: begin
               x_in = 48'sd0;
               y_in = 48'sd0;
               heading_in = 32'd0;
            end
            OP_SET: begin
               x_in = new_x_ff;
               y_in = new_y_ff;
               heading_in = new_heading_ff;
            end
            default: begin
               x_in = x_ff;
               y_in = y_ff;
               heading_in = heading_ff;
            end
         endcase
      end
   end

   // control state: mode, pose, stamp history
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         x_ff <= 48'sd0;
         y_ff <= 48'sd0;
         heading_ff <= 32'd0;
         last_stamp_ff <= 48'd0;
         seen_ff <= 1'b0;
      end else begin
         if (csr_write) mode_ff <= csr_integration_mode;
         x_ff <= x_in;
         y_ff <= y_in;
         heading_ff <= heading_in;
         if (ctl.cmd == CMD_LOAD && req_op == OP_VELOCITY) begin
            last_stamp_ff <= req_stamp;
            seen_ff <= 1'b1;
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      case (ctl.cmd)
         CMD_LOAD: begin
            op_ff <= req_op;
            speed_ff <= req_linear_speed;
            yaw_ff <= req_yaw_rate;
            new_x_ff <= req_new_x;
            new_y_ff <= req_new_y;
            new_heading_ff <= req_new_heading;
            ts_ff <= ts_new;
         end
         CMD_PSAVE: begin
            prod_ff <= mul_ff[63:0];
            acc_ff <= 128'd0;
         end
         CMD_PART: begin
            if (ctl.step != STEP_W'(0)) acc_ff <= acc_ff + part_term;
         end
         CMD_ANGLE: begin
            cx_ff <= CORDIC_GAIN;
            cy_ff <= 34'sd0;
            z_ff <= 34'($signed(h_fold));
            flip_ff <= h_flip;
         end
         CMD_ROT: begin
            if (!z_ff[33]) begin
               cx_ff <= cx_ff - cy_sh;
               cy_ff <= cy_ff + cx_sh;
               z_ff <= z_ff - atan_ext;
            end else begin
               cx_ff <= cx_ff + cy_sh;
               cy_ff <= cy_ff - cx_sh;
               z_ff <= z_ff + atan_ext;
            end
         end
         CMD_TRIG: begin
            cos_ff <= flip_ff ? -cx_cl : cx_cl;
            sin_ff <= flip_ff ? -cy_cl : cy_cl;
         end
         CMD_ROUND_VC, CMD_ROUND_VS: vc_ff <= rnd30_sum[62:30];
         CMD_MUL_VS: dx_ff <= rndf_sum[65:FRAC_BITS];
         CMD_ROUND_DY: dy_ff <= rndf_sum[65:FRAC_BITS];
         CMD_COMMIT_VEL: begin
            echo_v_ff <= speed_ff;
            echo_w_ff <= yaw_ff;
            mode_used_ff <= mode_ff;
         end
         CMD_COMMIT_POSE: begin
            echo_v_ff <= 32'sd0;
            echo_w_ff <= 32'sd0;
            mode_used_ff <= mode_ff;
         end
         default: begin
         end
      endcase
   end

   // pose registers only change at commit, so they feed the result directly
   assign rsp_pose_x = x_ff;
   assign rsp_pose_y = y_ff;
   assign rsp_pose_heading = heading_ff;
   assign rsp_echo_speed = echo_v_ff;
   assign rsp_echo_yaw_rate = echo_w_ff;
   assign rsp_mode_used = mode_used_ff;

endmodule
`default_nettype wire

// ----- src/opi_ctrl.sv -----
`default_nettype none
module opi_ctrl #(
   parameter int TRIG_ITERATIONS = opi_pkg::TRIG_ITER_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic [1:0]            req_op,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output opi_pkg::opi_ctrl_type      ctl
);
   import opi_pkg::*;

   opi_state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   // state, counter and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // sequencing and commands
   always_comb begin
      out_free = !rsp_valid_ff || rsp_ready;
      state_in = state_ff;
      step_in = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready = 1'b0;
      ctl.cmd = CMD_IDLE;
      ctl.step = step_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.cmd = CMD_LOAD;
               state_in = (req_op == OP_VELOCITY) ? S_PROD : S_POSE;
            end
         end
         S_PROD: begin
            ctl.cmd = CMD_PROD;
            state_in = S_PSAVE;
         end
         S_PSAVE: begin
            ctl.cmd = CMD_PSAVE;
            step_in = '0;
            state_in = S_PART;
         end
         S_PART: begin
            ctl.cmd = CMD_PART;
            if (step_ff == STEP_W'(PARTS)) begin
               step_in = '0;
               state_in = S_ANGLE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_ANGLE: begin
            ctl.cmd = CMD_ANGLE;
            step_in = '0;
            state_in = S_ROT;
         end
         S_ROT: begin
            ctl.cmd = CMD_ROT;
            if (step_ff == STEP_W'(TRIG_ITERATIONS - 1)) begin
               step_in = '0;
               state_in = S_TRIG;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         S_TRIG: begin
            ctl.cmd = CMD_TRIG;
            state_in = S_MUL_VC;
         end
         S_MUL_VC: begin
            ctl.cmd = CMD_MUL_VC;
            state_in = S_ROUND_VC;
         end
         S_ROUND_VC: begin
            ctl.cmd = CMD_ROUND_VC;
            state_in = S_MUL_VCT;
         end
         S_MUL_VCT: begin
            ctl.cmd = CMD_MUL_VCT;
            state_in = S_MUL_VS;
         end
         S_MUL_VS: begin
            ctl.cmd = CMD_MUL_VS;
            state_in = S_ROUND_VS;
         end
         S_ROUND_VS: begin
            ctl.cmd = CMD_ROUND_VS;
            state_in = S_MUL_VST;
         end
         S_MUL_VST: begin
            ctl.cmd = CMD_MUL_VST;
            state_in = S_ROUND_DY;
         end
         S_ROUND_DY: begin
            ctl.cmd = CMD_ROUND_DY;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) begin
               ctl.cmd = CMD_COMMIT_VEL;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_POSE: begin
            if (out_free) begin
               ctl.cmd = CMD_COMMIT_POSE;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ----- src/opi_checker.sv -----
`default_nettype none
module opi_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready
);

   // a waiting result is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // one request at a time: busy right after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result appears in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result too early");

   // reset leaves the block empty and ready
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind odometry_pose_integrator_core opi_checker u_opi_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready)
);
`default_nettype wire
